// File: rtl/tls_rs_pkg.sv
// Shared types and constants for the TLS record splitter.
// No dependencies; used by tls_rs_core, tls_rs_obuf and the top level.
package tls_rs_pkg;

  localparam logic [7:0] REC_HANDSHAKE = 8'h16;
  localparam logic [7:0] VER_MAJOR     = 8'h03;
  localparam logic [7:0] VER_MINOR     = 8'h01;
  localparam int unsigned SPLIT_MIN     = 50;
  localparam int unsigned SHORT_PAYLOAD = 10;
  localparam int unsigned HDR_LEN       = 5;
  localparam int unsigned MAX_RESULTS   = 6;
  localparam int unsigned CHUNK_W       = 15;
  localparam int unsigned REC_LEN_W     = 16;

  typedef enum logic [3:0] {
    MODE_HDR   = 4'b0001,
    MODE_COPY  = 4'b0010,
    MODE_SPLIT = 4'b0100,
    MODE_REST  = 4'b1000
  } mode_t;

  // Bytes caused by one input beat; data[0] goes out first
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [2:0]                  count;
    logic                        eop;
  } result_t;

endpackage

// File: rtl/tls_record_splitter_unit.sv
// TLS record splitter top level: input register, framing core, output register.
// An accepted beat passes through the input register and then the output register.
// Throughput: one byte per cycle while each byte gives one beat and m_tready is high; a
// byte opening a split chunk gives 6 beats and one that completes or cuts short a header
// up to 5, and the output register then holds input back until its last beat is being taken.
// Reset (rst, synchronous, active high) clears framing state; chunk_size returns to 1.
module tls_record_splitter_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // in_byte, payload_length
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // out_byte
  output logic                             m_tuser,   // end_of_run
  output logic                             m_tlast,   // end_of_packet
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tls_rs_pkg::CHUNK_W-1:0]   cfg_data   // chunk_size
);

  logic                            in_q_valid;
  logic [7:0]                      in_q_byte;
  logic [15:0]                     in_q_len;
  logic [tls_rs_pkg::CHUNK_W-1:0]  chunk_size;
  logic                            can_load;
  logic                            fire;
  tls_rs_pkg::result_t             res;

  assign fire      = in_q_valid && can_load;
  assign s_tready  = !in_q_valid || can_load;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      chunk_size <= tls_rs_pkg::CHUNK_W'(1);
    end else begin
      if (s_tvalid && s_tready) begin
        in_q_valid <= 1'b1;
      end else if (fire) begin
        in_q_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        chunk_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q_byte <= s_tdata[7:0];
      in_q_len  <= s_tdata[23:8];
    end
  end

  tls_rs_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .in_byte        (in_q_byte),
    .payload_length (in_q_len),
    .chunk_size     (chunk_size),
    .res            (res)
  );

  tls_rs_obuf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .res           (res),
    .can_load      (can_load),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_byte      (m_tdata),
    .end_of_run    (m_tuser),
    .end_of_packet (m_tlast)
  );

endmodule

// File: rtl/tls_rs_core.sv
// Record framing state and per-byte result builder for the TLS record splitter.
// Depends on tls_rs_pkg.
module tls_rs_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [7:0]                          in_byte,
  input  logic [15:0]                         payload_length,
  input  logic [tls_rs_pkg::CHUNK_W-1:0]      chunk_size,
  output tls_rs_pkg::result_t                 res
);

  localparam int SUM_W = ((LENGTH_BITS > tls_rs_pkg::REC_LEN_W) ?
                          LENGTH_BITS : tls_rs_pkg::REC_LEN_W) + 2;

  logic [LENGTH_BITS-1:0]             pos, pos_next;
  tls_rs_pkg::mode_t                  mode, mode_next;
  logic [2:0]                         hc, hc_next;
  logic [tls_rs_pkg::REC_LEN_W-1:0]   rr, rr_next;
  logic [tls_rs_pkg::CHUNK_W-1:0]     cr, cr_next;
  logic [3:0][7:0]                    held;
  logic                               held_we;

  logic [LENGTH_BITS-1:0]             len;
  logic [LENGTH_BITS-1:0]             len_left;
  logic                               endp, past_end, hdr_short, hdr_done;
  logic                               overrun, split_start;
  logic [tls_rs_pkg::REC_LEN_W-1:0]   rl, rr_dec;
  logic [tls_rs_pkg::CHUNK_W-1:0]     cs, chunk, cr_eff;
  logic                               do_flush;

  assign len       = payload_length[LENGTH_BITS-1:0];
  assign endp      = ({1'b0, pos} + 1'b1) >= {1'b0, len};
  assign past_end  = pos >= len;
  assign len_left  = len - pos;
  assign hdr_short = (hc == 3'd0) &&
                     (((pos == '0) && (len < LENGTH_BITS'(tls_rs_pkg::SHORT_PAYLOAD))) ||
                      (len_left < LENGTH_BITS'(tls_rs_pkg::HDR_LEN)));
  assign hdr_done  = (hc == 3'(tls_rs_pkg::HDR_LEN - 1));
  assign rl        = {held[3], in_byte};
  assign overrun   = (SUM_W'(pos) + SUM_W'(1) + SUM_W'(rl)) > SUM_W'(len);
  assign split_start = (held[0] == tls_rs_pkg::REC_HANDSHAKE) &&
                       (rl > tls_rs_pkg::REC_LEN_W'(tls_rs_pkg::SPLIT_MIN));
  assign rr_dec    = (rr == '0) ? '0 : rr - 1'b1;

  // chunk length for a fresh split header
  assign cs     = (chunk_size == '0) ? tls_rs_pkg::CHUNK_W'(1) : chunk_size;
  always_comb begin
    chunk = (rr < tls_rs_pkg::REC_LEN_W'(cs)) ? rr[tls_rs_pkg::CHUNK_W-1:0] : cs;
    if (chunk == '0) begin
      chunk = tls_rs_pkg::CHUNK_W'(1);
    end
  end
  assign cr_eff = (cr == '0) ? chunk : cr;

  always_comb begin
    pos_next  = pos + 1'b1;
    mode_next = mode;
    hc_next   = hc;
    rr_next   = rr;
    cr_next   = cr;
    held_we   = 1'b0;
    do_flush  = 1'b0;
    res.data  = '0;
    res.count = 3'd0;
    res.eop   = endp;

    if (past_end) begin
      do_flush = 1'b1;
    end else begin
      case (mode)
        tls_rs_pkg::MODE_HDR: begin
          if (hdr_short) begin
            mode_next   = tls_rs_pkg::MODE_REST;
            res.data[0] = in_byte;
            res.count   = 3'd1;
          end else begin
            held_we = !hc[2];
            hc_next = hc + 1'b1;
            if (hdr_done) begin
              hc_next = 3'd0;
              if (overrun) begin
                do_flush  = 1'b1;
                mode_next = tls_rs_pkg::MODE_REST;
              end else if (split_start) begin
                rr_next   = rl;
                cr_next   = '0;
                mode_next = tls_rs_pkg::MODE_SPLIT;
              end else begin
                do_flush  = 1'b1;
                rr_next   = rl;
                mode_next = (rl != '0) ? tls_rs_pkg::MODE_COPY : tls_rs_pkg::MODE_HDR;
              end
            end else if (endp) begin
              do_flush = 1'b1;
            end
          end
        end
        tls_rs_pkg::MODE_COPY: begin
          res.data[0] = in_byte;
          res.count   = 3'd1;
          rr_next     = rr_dec;
          if (rr_dec == '0) begin
            mode_next = tls_rs_pkg::MODE_HDR;
          end
        end
        tls_rs_pkg::MODE_SPLIT: begin
          if (cr == '0) begin
            res.data[0] = tls_rs_pkg::REC_HANDSHAKE;
            res.data[1] = tls_rs_pkg::VER_MAJOR;
            res.data[2] = tls_rs_pkg::VER_MINOR;
            res.data[3] = {1'b0, chunk[14:8]};
            res.data[4] = chunk[7:0];
            res.data[5] = in_byte;
            res.count   = 3'd6;
          end else begin
            res.data[0] = in_byte;
            res.count   = 3'd1;
          end
          cr_next = cr_eff - 1'b1;
          rr_next = rr_dec;
          if (rr_dec == '0) begin
            mode_next = tls_rs_pkg::MODE_HDR;
            cr_next   = '0;
          end
        end
        default: begin
          res.data[0] = in_byte;
          res.count   = 3'd1;
        end
      endcase
    end

    // held header bytes first, then this beat
    if (do_flush) begin
      res.data[3:0] = held;
      res.data[hc]  = in_byte;
      res.count     = hc + 1'b1;
      hc_next       = 3'd0;
    end

    if (endp) begin
      pos_next  = '0;
      mode_next = tls_rs_pkg::MODE_HDR;
      hc_next   = 3'd0;
      rr_next   = '0;
      cr_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      mode <= tls_rs_pkg::MODE_HDR;
      hc   <= 3'd0;
      rr   <= '0;
      cr   <= '0;
    end else if (fire) begin
      pos  <= pos_next;
      mode <= mode_next;
      hc   <= hc_next;
      rr   <= rr_next;
      cr   <= cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && held_we) begin
      held[hc[1:0]] <= in_byte;
    end
  end

endmodule

// File: rtl/tls_rs_obuf.sv
// Output register for the TLS record splitter: holds the bytes of one input beat
// and shifts them out one per cycle while m_tready is high. Depends on tls_rs_pkg.
module tls_rs_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tls_rs_pkg::result_t res,
  output logic                can_load,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          out_byte,
  output logic                end_of_run,
  output logic                end_of_packet
);

  logic [tls_rs_pkg::MAX_RESULTS-1:0][7:0] data;
  logic [2:0]                              cnt;
  logic                                    eop;
  logic                                    take;

  assign take          = (cnt != 3'd0) && m_tready;
  assign can_load      = (cnt == 3'd0) || ((cnt == 3'd1) && m_tready);
  assign m_tvalid      = (cnt != 3'd0);
  assign out_byte      = data[0];
  assign end_of_run    = (cnt == 3'd1);
  assign end_of_packet = (cnt == 3'd1) && eop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res.data;
      eop  <= res.eop;
    end else if (take) begin
      data <= {8'h00, data[tls_rs_pkg::MAX_RESULTS-1:1]};
    end
  end

endmodule
